/* src/spcd_pkg.sv */
// Shared widths, reset values and codes for the segment pair closest distance block.
`timescale 1ns / 1ps
package spcd_pkg;
   localparam int COORD_W   = 24;
   localparam int DIFF_W    = 25;
   localparam int PROD_W    = 50;
   localparam int SUM_W     = 51;
   localparam int MUL_W     = 52;
   localparam int MUL_H     = 26;
   localparam int WIDE_W    = 104;
   localparam int MAG_W     = 103;
   localparam int PARAM_W   = 17;
   localparam int Q_W       = 16;
   localparam int DX_W      = 44;
   localparam int ACC_W     = 89;
   localparam int DIST_W    = 50;
   localparam int SAT_BIT   = 82;
   localparam int LEN_EPS_W = 24;
   localparam int PAR_EPS_W = 32;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;
   localparam int NUM_PROD  = 15;
   localparam int NUM_SUM   = 5;

   localparam int ST_DIV0   = 6;
   localparam int ST_PARAM  = ST_DIV0 + Q_W + 1;
   localparam int ST_PMUL   = ST_PARAM + 1;
   localparam int ST_DX     = ST_PMUL + 1;
   localparam int ST_LAST   = ST_DX + 3;
   localparam int PA_N      = ST_LAST - ST_PARAM + 1;

   localparam logic [PARAM_W-1:0]   PARAM_ONE   = 17'h10000;
   localparam logic [LEN_EPS_W-1:0] LEN_EPS_RST = 24'd17;
   localparam logic [PAR_EPS_W-1:0] PAR_EPS_RST = 32'd281474977;

   localparam logic REG_LEN_EPS = 1'b0;
   localparam logic REG_PAR_EPS = 1'b1;

   typedef enum logic [2:0] {
      PC_ZERO = 3'b001,
      PC_ONE  = 3'b010,
      PC_DIV  = 3'b100
   } pcode_type;

   typedef struct packed {
      logic [2:0][DIFF_W-1:0] d1;
      logic [2:0][DIFF_W-1:0] d2;
      logic [2:0][DIFF_W-1:0] r;
   } geo_type;
endpackage

/* src/segment_pair_closest_distance.sv */
// Top level: pipelined closest distance and parameters of two 3D segments.
`timescale 1ns / 1ps
// Usage:
//   req_* carries one item: two segments as start and end points, signed Q12.12.
//   rsp_* returns one item per request: dist_sq (Q26.24, saturating) and the
//   two clamped parameters (Q1.16, 65536 is one), in request order.
//   csr_* is an APB-style port: length_eps at 0x0, parallel_eps at 0x4.
//   Write configuration only while no item is in flight.
// Timing:
//   One item per cycle enters the pipeline while it is not stalled. The result
//   passes through 6 stages of differences, dot products, 104-bit products
//   and determinant, 1 magnitude stage, 16 stages of restoring division (one
//   quotient bit each), then parameter select, distance multiply and sum stages.
// Reset clears all valid bits and loads the register reset values.
// Stall: when rsp_ready is low with a result waiting, the whole pipeline
// holds and req_ready drops; nothing is lost or repeated.
module segment_pair_closest_distance (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [spcd_pkg::COORD_W-1:0]  req_seg1_start_x,
   input  logic signed [spcd_pkg::COORD_W-1:0]  req_seg1_start_y,
   input  logic signed [spcd_pkg::COORD_W-1:0]  req_seg1_start_z,
   input  logic signed [spcd_pkg::COORD_W-1:0]  req_seg1_end_x,
   input  logic signed [spcd_pkg::COORD_W-1:0]  req_seg1_end_y,
   input  logic signed [spcd_pkg::COORD_W-1:0]  req_seg1_end_z,
   input  logic signed [spcd_pkg::COORD_W-1:0]  req_seg2_start_x,
   input  logic signed [spcd_pkg::COORD_W-1:0]  req_seg2_start_y,
   input  logic signed [spcd_pkg::COORD_W-1:0]  req_seg2_start_z,
   input  logic signed [spcd_pkg::COORD_W-1:0]  req_seg2_end_x,
   input  logic signed [spcd_pkg::COORD_W-1:0]  req_seg2_end_y,
   input  logic signed [spcd_pkg::COORD_W-1:0]  req_seg2_end_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic        [spcd_pkg::DIST_W-1:0]   rsp_dist_sq,
   output logic        [spcd_pkg::PARAM_W-1:0]  rsp_param_first,
   output logic        [spcd_pkg::PARAM_W-1:0]  rsp_param_second,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic        [spcd_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic        [spcd_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic        [spcd_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import spcd_pkg::*;

   logic                      en;
   logic [ST_LAST:0]          v_ff;
   logic [LEN_EPS_W-1:0]      len_eps_ff;
   logic [PAR_EPS_W-1:0]      par_eps_ff;

   logic signed [COORD_W-1:0] p1s [3], p1e [3], p2s [3], p2e [3];
   geo_type                   geo_in;
   geo_type                   geo_ff [ST_DX];

   logic signed [PROD_W-1:0]  prod_in [NUM_PROD], prod_ff [NUM_PROD];
   logic signed [SUM_W-1:0]   sum_in [NUM_SUM], sum_ff [NUM_SUM];
   logic                      len_ok_in;
   logic                      len_ok_ff [2];

   logic signed [WIDE_W-1:0]  m_ae, m_bb, m_bf, m_ce, m_af, m_bc;
   logic signed [WIDE_W-1:0]  den_ff, ns_ff, nt_ff;
   logic                      ok5_ff;

   logic [MAG_W-1:0]          den_mag_in, ns_mag_in, nt_mag_in;
   logic                      den_ok;
   pcode_type                 cs_in, ct_in;

   logic [MAG_W-1:0]          dm_ff [Q_W+1];
   logic [MAG_W-1:0]          rs_ff [Q_W+1], rt_ff [Q_W+1];
   logic [Q_W-1:0]            qs_ff [Q_W+1], qt_ff [Q_W+1];
   pcode_type                 cs_ff [Q_W+1], ct_ff [Q_W+1];
   logic [MAG_W-1:0]          rs_in [Q_W], rt_in [Q_W];
   logic [Q_W-1:0]            qs_in [Q_W], qt_in [Q_W];

   logic [PARAM_W-1:0]        ps_in, pt_in;
   logic [PARAM_W-1:0]        pa_s_ff [PA_N], pa_t_ff [PA_N];

   logic signed [DX_W-1:0]    ms_in [3], mt_in [3], ms_ff [3], mt_ff [3];
   logic signed [DX_W-1:0]    dx_in [3], dx_ff [3];
   logic signed [WIDE_W-1:0]  sq [3];
   logic [ACC_W-1:0]          acc;
   logic [DIST_W-1:0]         dist_in, dist_ff;

   assign en        = !v_ff[ST_LAST] || rsp_ready;
   assign req_ready = en;

   // configuration port
   assign csr_pready = 1'b1;
   always_comb begin
      case (csr_paddr[2])
         REG_LEN_EPS: csr_prdata = CSR_DW'(len_eps_ff);
         REG_PAR_EPS: csr_prdata = CSR_DW'(par_eps_ff);
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_eps_ff <= LEN_EPS_RST;
         par_eps_ff <= PAR_EPS_RST;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_paddr[2])
            REG_LEN_EPS: len_eps_ff <= csr_pwdata[LEN_EPS_W-1:0];
            REG_PAR_EPS: par_eps_ff <= csr_pwdata[PAR_EPS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[ST_LAST-1:0], req_valid};
      end
   end

   // stage 0: directions and offset
   always_comb begin
      p1s = '{req_seg1_start_x, req_seg1_start_y, req_seg1_start_z};
      p1e = '{req_seg1_end_x, req_seg1_end_y, req_seg1_end_z};
      p2s = '{req_seg2_start_x, req_seg2_start_y, req_seg2_start_z};
      p2e = '{req_seg2_end_x, req_seg2_end_y, req_seg2_end_z};
      for (int k = 0; k < 3; k++) begin
         geo_in.d1[k] = DIFF_W'(p1e[k]) - DIFF_W'(p1s[k]);
         geo_in.d2[k] = DIFF_W'(p2e[k]) - DIFF_W'(p2s[k]);
         geo_in.r[k]  = DIFF_W'(p1s[k]) - DIFF_W'(p2s[k]);
      end
   end

   // stage 1: per-axis products; stage 2: dot products
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod_in[k]      = $signed(geo_ff[0].d1[k]) * $signed(geo_ff[0].d1[k]);
         prod_in[3 + k]  = $signed(geo_ff[0].d2[k]) * $signed(geo_ff[0].d2[k]);
         prod_in[6 + k]  = $signed(geo_ff[0].d1[k]) * $signed(geo_ff[0].d2[k]);
         prod_in[9 + k]  = $signed(geo_ff[0].d1[k]) * $signed(geo_ff[0].r[k]);
         prod_in[12 + k] = $signed(geo_ff[0].d2[k]) * $signed(geo_ff[0].r[k]);
      end
      for (int j = 0; j < NUM_SUM; j++) begin
         sum_in[j] = SUM_W'(prod_ff[3*j]) + SUM_W'(prod_ff[3*j+1]) + SUM_W'(prod_ff[3*j+2]);
      end
      len_ok_in = ($unsigned(sum_ff[0]) > SUM_W'(len_eps_ff))
               && ($unsigned(sum_ff[1]) > SUM_W'(len_eps_ff));
   end

   // stages 3-4: wide products  (sum order: a, e, b, c, f)
   spcd_mul u_mul_ae (.clock, .en, .mul_a(MUL_W'(sum_ff[0])), .mul_b(MUL_W'(sum_ff[1])),
                      .mul_p(m_ae));
   spcd_mul u_mul_bb (.clock, .en, .mul_a(MUL_W'(sum_ff[2])), .mul_b(MUL_W'(sum_ff[2])),
                      .mul_p(m_bb));
   spcd_mul u_mul_bf (.clock, .en, .mul_a(MUL_W'(sum_ff[2])), .mul_b(MUL_W'(sum_ff[4])),
                      .mul_p(m_bf));
   spcd_mul u_mul_ce (.clock, .en, .mul_a(MUL_W'(sum_ff[3])), .mul_b(MUL_W'(sum_ff[1])),
                      .mul_p(m_ce));
   spcd_mul u_mul_af (.clock, .en, .mul_a(MUL_W'(sum_ff[0])), .mul_b(MUL_W'(sum_ff[4])),
                      .mul_p(m_af));
   spcd_mul u_mul_bc (.clock, .en, .mul_a(MUL_W'(sum_ff[2])), .mul_b(MUL_W'(sum_ff[3])),
                      .mul_p(m_bc));

   // stage 6: magnitudes and parameter codes
   always_comb begin
      den_mag_in = den_ff[WIDE_W-1] ? MAG_W'(-den_ff) : MAG_W'(den_ff);
      ns_mag_in  = ns_ff[WIDE_W-1] ? MAG_W'(-ns_ff) : MAG_W'(ns_ff);
      nt_mag_in  = nt_ff[WIDE_W-1] ? MAG_W'(-nt_ff) : MAG_W'(nt_ff);
      den_ok     = ok5_ff && (den_mag_in > MAG_W'(par_eps_ff));
      if (!den_ok || ns_mag_in == '0 || ns_ff[WIDE_W-1] != den_ff[WIDE_W-1]) begin
         cs_in = PC_ZERO;
      end else if (ns_mag_in >= den_mag_in) begin
         cs_in = PC_ONE;
      end else begin
         cs_in = PC_DIV;
      end
      if (!den_ok || nt_mag_in == '0 || nt_ff[WIDE_W-1] != den_ff[WIDE_W-1]) begin
         ct_in = PC_ZERO;
      end else if (nt_mag_in >= den_mag_in) begin
         ct_in = PC_ONE;
      end else begin
         ct_in = PC_DIV;
      end
   end

   // division steps, one quotient bit per stage
   always_comb begin
      for (int j = 0; j < Q_W; j++) begin
         rs_in[j] = {rs_ff[j][MAG_W-2:0], 1'b0};
         qs_in[j] = {qs_ff[j][Q_W-2:0], 1'b0};
         if (rs_in[j] >= dm_ff[j]) begin
            rs_in[j]    = rs_in[j] - dm_ff[j];
            qs_in[j][0] = 1'b1;
         end
         rt_in[j] = {rt_ff[j][MAG_W-2:0], 1'b0};
         qt_in[j] = {qt_ff[j][Q_W-2:0], 1'b0};
         if (rt_in[j] >= dm_ff[j]) begin
            rt_in[j]    = rt_in[j] - dm_ff[j];
            qt_in[j][0] = 1'b1;
         end
      end
   end

   always_comb begin
      case (cs_ff[Q_W])
         PC_ONE:  ps_in = PARAM_ONE;
         PC_DIV:  ps_in = PARAM_W'(qs_ff[Q_W]);
         default: ps_in = '0;
      endcase
      case (ct_ff[Q_W])
         PC_ONE:  pt_in = PARAM_ONE;
         PC_DIV:  pt_in = PARAM_W'(qt_ff[Q_W]);
         default: pt_in = '0;
      endcase
   end

   // point difference per axis
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ms_in[k] = DX_W'($signed(geo_ff[ST_PMUL-1].d1[k]) * $signed({1'b0, pa_s_ff[0]}));
         mt_in[k] = DX_W'($signed(geo_ff[ST_PMUL-1].d2[k]) * $signed({1'b0, pa_t_ff[0]}));
         dx_in[k] = (DX_W'($signed(geo_ff[ST_DX-1].r[k])) <<< Q_W) + ms_ff[k] - mt_ff[k];
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_sq
      spcd_mul u_mul_sq (.clock, .en, .mul_a(MUL_W'(dx_ff[k])), .mul_b(MUL_W'(dx_ff[k])),
                         .mul_p(sq[k]));
   end

   always_comb begin
      acc = ACC_W'(sq[0]) + ACC_W'(sq[1]) + ACC_W'(sq[2]);
      if (acc[ACC_W-1:SAT_BIT] != '0) begin
         dist_in = '1;
      end else begin
         dist_in = acc[SAT_BIT-1:SAT_BIT-DIST_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         geo_ff[0] <= geo_in;
         for (int s = 1; s < ST_DX; s++) begin
            geo_ff[s] <= geo_ff[s-1];
         end
         prod_ff      <= prod_in;
         sum_ff       <= sum_in;
         len_ok_ff[0] <= len_ok_in;
         len_ok_ff[1] <= len_ok_ff[0];
         den_ff       <= m_ae - m_bb;
         ns_ff        <= m_bf - m_ce;
         nt_ff        <= m_af - m_bc;
         ok5_ff       <= len_ok_ff[1];
         dm_ff[0]     <= den_mag_in;
         rs_ff[0]     <= ns_mag_in;
         rt_ff[0]     <= nt_mag_in;
         qs_ff[0]     <= '0;
         qt_ff[0]     <= '0;
         cs_ff[0]     <= cs_in;
         ct_ff[0]     <= ct_in;
         for (int j = 0; j < Q_W; j++) begin
            dm_ff[j+1] <= dm_ff[j];
            rs_ff[j+1] <= rs_in[j];
            rt_ff[j+1] <= rt_in[j];
            qs_ff[j+1] <= qs_in[j];
            qt_ff[j+1] <= qt_in[j];
            cs_ff[j+1] <= cs_ff[j];
            ct_ff[j+1] <= ct_ff[j];
         end
         pa_s_ff[0] <= ps_in;
         pa_t_ff[0] <= pt_in;
         for (int s = 1; s < PA_N; s++) begin
            pa_s_ff[s] <= pa_s_ff[s-1];
            pa_t_ff[s] <= pa_t_ff[s-1];
         end
         ms_ff   <= ms_in;
         mt_ff   <= mt_in;
         dx_ff   <= dx_in;
         dist_ff <= dist_in;
      end
   end

   assign rsp_valid        = v_ff[ST_LAST];
   assign rsp_dist_sq      = dist_ff;
   assign rsp_param_first  = pa_s_ff[PA_N-1];
   assign rsp_param_second = pa_t_ff[PA_N-1];
endmodule

/* src/spcd_mul.sv */
// Two-stage signed 52x52 multiplier built from four registered partial products.
`timescale 1ns / 1ps
module spcd_mul (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [spcd_pkg::MUL_W-1:0]    mul_a,
   input  logic signed [spcd_pkg::MUL_W-1:0]    mul_b,
   output logic signed [spcd_pkg::WIDE_W-1:0]   mul_p
);
   import spcd_pkg::*;

   logic signed [MUL_H-1:0]   ah, bh;
   logic        [MUL_H-1:0]   al, bl;
   logic signed [2*MUL_H-1:0] hh_in, hh_ff;
   logic signed [2*MUL_H:0]   hl_in, hl_ff, lh_in, lh_ff;
   logic        [2*MUL_H-1:0] ll_in, ll_ff;
   logic signed [WIDE_W-1:0]  p_in, p_ff;

   always_comb begin
      ah    = mul_a[MUL_W-1:MUL_H];
      bh    = mul_b[MUL_W-1:MUL_H];
      al    = mul_a[MUL_H-1:0];
      bl    = mul_b[MUL_H-1:0];
      hh_in = ah * bh;
      hl_in = ah * $signed({1'b0, bl});
      lh_in = $signed({1'b0, al}) * bh;
      ll_in = al * bl;
      p_in  = (WIDE_W'(hh_ff) <<< (2 * MUL_H)) + (WIDE_W'(hl_ff) <<< MUL_H)
            + (WIDE_W'(lh_ff) <<< MUL_H) + $signed(WIDE_W'(ll_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         lh_ff <= lh_in;
         ll_ff <= ll_in;
         p_ff  <= p_in;
      end
   end

   assign mul_p = p_ff;
endmodule
